>>> rtl/core/bcis_pkg.sv
`timescale 1ns / 1ps
// Package for the bilinear cover-fit image scaler core.
// Holds the configuration register indexes, store geometry and sequencer state type.
package bcis_pkg;

	localparam int STORE_AW = 16;
	localparam int PIX_W    = 24;
	localparam int FRAC_W   = 16;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 12;
	localparam int COORD_W  = 11;

	localparam logic [CFG_IW-1:0] CFG_SRC_W = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SRC_H = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_DST_W = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DST_H = 3'd3;

	typedef enum logic [2:0] {
		SEQ_LIMIT,
		SEQ_COMPARE,
		SEQ_DIVIDE,
		SEQ_SCALE,
		SEQ_CROP,
		SEQ_IDLE
	} seq_state_t;

endpackage

>>> rtl/core/bilinear_cover_image_scaler_core.sv
`timescale 1ns / 1ps
// Bilinear cover-fit scaler core: image store, scale sequencer and render pipeline.
// Depends on bcis_pkg.
// pixel_valid rises once a render has passed stages one to seven and the output register;
// loads give none. Throughput: one item per cycle, loads and renders mixed, set by the
// dual-read image stores, while the output is not stalled. After reset and each register
// write the sequencer runs limit, compare, divide, scale and crop, holding item_ready low.
// Reset restores the register defaults; the image store is not cleared.
module bilinear_cover_image_scaler_core
	import bcis_pkg::*;
#(
	parameter int MAX_SOURCE_DIM = 256,
	parameter int MAX_TARGET_DIM = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 action,
	input  logic [15:0]          source_index,
	input  logic [7:0]           load_red,
	input  logic [7:0]           load_green,
	input  logic [7:0]           load_blue,
	input  logic [COORD_W-1:0]   target_x,
	input  logic [COORD_W-1:0]   target_y,
	output logic                 pixel_valid,
	input  logic                 pixel_ready,
	output logic [15:0]          pixel_rgb565
);

	localparam int SDW = $clog2(MAX_SOURCE_DIM + 1);
	localparam int TDW = $clog2(MAX_TARGET_DIM + 1);
	localparam int LW  = 13;
	localparam int DVW = SDW + FRAC_W;
	localparam int CNW = $clog2(DVW + 1);
	localparam int PRW = DVW + TDW;
	localparam int MPW = DVW + COORD_W;
	localparam int PW  = MPW + 1;
	localparam int IPW = PW - FRAC_W;
	localparam int RW  = 2 * SDW;

	logic [8:0]  src_w_q, src_h_q;
	logic [11:0] dst_w_q, dst_h_q;
	logic [SDW-1:0] iw_q, ih_q;
	logic [TDW-1:0] w_q, h_q, den_q;
	logic [TDW-1:0] rem_q;
	logic [DVW-1:0] quot_q, step_q, crop_x_q, crop_y_q;
	logic [CNW-1:0] cnt_q;
	logic [PRW-1:0] prod_w_q, prod_h_q;
	seq_state_t state_q, state_d;

	logic [TDW:0] r_shift, r_sub;
	logic         r_ge;
	logic [LW-1:0] lim_iw, lim_ih, lim_w, lim_h;
	logic [RW+TDW-1:0] cmp_a, cmp_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 9'd256;
			src_h_q <= 9'd256;
			dst_w_q <= 12'd640;
			dst_h_q <= 12'd480;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SRC_W: src_w_q <= cfg_data[8:0];
				CFG_SRC_H: src_h_q <= cfg_data[8:0];
				CFG_DST_W: dst_w_q <= cfg_data;
				CFG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_LIMIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_LIMIT:   state_d = SEQ_COMPARE;
			SEQ_COMPARE: state_d = SEQ_DIVIDE;
			SEQ_DIVIDE:  if (cnt_q == CNW'(DVW - 1)) state_d = SEQ_SCALE;
			SEQ_SCALE:   state_d = SEQ_CROP;
			SEQ_CROP:    state_d = SEQ_IDLE;
			SEQ_IDLE:    state_d = SEQ_IDLE;
			default:     state_d = SEQ_LIMIT;
		endcase
		if (cfg_write) state_d = SEQ_LIMIT;
	end

	always_comb begin
		lim_iw = (src_w_q == 9'd0) ? LW'(1) :
			(LW'(src_w_q) > LW'(MAX_SOURCE_DIM)) ? LW'(MAX_SOURCE_DIM) : LW'(src_w_q);
		lim_ih = (src_h_q == 9'd0) ? LW'(1) :
			(LW'(src_h_q) > LW'(MAX_SOURCE_DIM)) ? LW'(MAX_SOURCE_DIM) : LW'(src_h_q);
		lim_w = (dst_w_q == 12'd0) ? LW'(1) :
			(LW'(dst_w_q) > LW'(MAX_TARGET_DIM)) ? LW'(MAX_TARGET_DIM) : LW'(dst_w_q);
		lim_h = (dst_h_q == 12'd0) ? LW'(1) :
			(LW'(dst_h_q) > LW'(MAX_TARGET_DIM)) ? LW'(MAX_TARGET_DIM) : LW'(dst_h_q);
		cmp_a = (RW+TDW)'(iw_q) * (RW+TDW)'(h_q);
		cmp_b = (RW+TDW)'(ih_q) * (RW+TDW)'(w_q);
		r_shift = {rem_q, quot_q[DVW-1]};
		r_ge = r_shift >= {1'b0, den_q};
		r_sub = r_shift - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_LIMIT: begin
				iw_q <= SDW'(lim_iw);
				ih_q <= SDW'(lim_ih);
				w_q <= TDW'(lim_w);
				h_q <= TDW'(lim_h);
			end
			SEQ_COMPARE: begin
				den_q <= (cmp_a > cmp_b) ? h_q : w_q;
				quot_q <= {((cmp_a > cmp_b) ? ih_q : iw_q), {FRAC_W{1'b0}}};
				rem_q <= '0;
				cnt_q <= '0;
			end
			SEQ_DIVIDE: begin
				rem_q <= r_ge ? r_sub[TDW-1:0] : r_shift[TDW-1:0];
				quot_q <= {quot_q[DVW-2:0], r_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			SEQ_SCALE: begin
				step_q <= quot_q;
				prod_w_q <= PRW'(quot_q) * PRW'(w_q);
				prod_h_q <= PRW'(quot_q) * PRW'(h_q);
			end
			SEQ_CROP: begin
				crop_x_q <= DVW'((PRW'({iw_q, {FRAC_W{1'b0}}}) - prod_w_q) >> 1);
				crop_y_q <= DVW'((PRW'({ih_q, {FRAC_W{1'b0}}}) - prod_h_q) >> 1);
			end
			default: ;
		endcase
	end

	logic adv, accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [15:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [PIX_W-1:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic [MPW-1:0] mx_s1, my_s1;
	logic [PW-1:0] px_s2, py_s2;
	logic [SDW-1:0] ix_s3, ix1_s3, iy_s3, iy1_s3, ix_s4, ix1_s4;
	logic [7:0] fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5, fx_s6, fy_s6, fy_s7;
	logic [RW-1:0] row0_s4, row1_s4;
	logic [STORE_AW-1:0] a00_s5, a01_s5, a10_s5, a11_s5;
	logic [PIX_W-1:0] rd00_s6, rd01_s6, rd10_s6, rd11_s6;
	logic [15:0] top_s7 [3];
	logic [15:0] bot_s7 [3];
	logic out_valid_q;
	logic [15:0] pix_q;

	logic [PIX_W-1:0] store_a_q [2**STORE_AW];
	logic [PIX_W-1:0] store_b_q [2**STORE_AW];

	logic [IPW-1:0] ipx, ipy;
	logic clx, cly;
	logic [STORE_AW-1:0] a00, a01, a10, a11;
	logic [15:0] top_d [3];
	logic [15:0] bot_d [3];
	logic [7:0] ch [3];
	logic [8:0] wfx, wfy;

	assign adv = !out_valid_q || pixel_ready;
	assign item_ready = adv && (state_q == SEQ_IDLE);
	assign accept = item_valid && item_ready;

	always_comb begin
		ipx = px_s2[PW-1:FRAC_W];
		ipy = py_s2[PW-1:FRAC_W];
		clx = ipx >= IPW'(iw_q - 1'b1);
		cly = ipy >= IPW'(ih_q - 1'b1);
		a00 = STORE_AW'(row0_s4 + RW'(ix_s4));
		a01 = STORE_AW'(row0_s4 + RW'(ix1_s4));
		a10 = STORE_AW'(row1_s4 + RW'(ix_s4));
		a11 = STORE_AW'(row1_s4 + RW'(ix1_s4));
		wfx = 9'd256 - 9'(fx_s6);
		wfy = 9'd256 - 9'(fy_s7);
		for (int c = 0; c < 3; c++) begin
			top_d[c] = 16'(17'(rd00_s6[16-8*c +: 8]) * 17'(wfx)
				+ 17'(rd01_s6[16-8*c +: 8]) * 17'(fx_s6));
			bot_d[c] = 16'(17'(rd10_s6[16-8*c +: 8]) * 17'(wfx)
				+ 17'(rd11_s6[16-8*c +: 8]) * 17'(fx_s6));
			ch[c] = 8'((25'(top_s7[c]) * 25'(wfy) + 25'(bot_s7[c]) * 25'(fy_s7)) >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5 && act_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action;
			idx_s1 <= source_index;
			rgb_s1 <= {load_red, load_green, load_blue};
			mx_s1 <= MPW'(target_x) * MPW'(step_q);
			my_s1 <= MPW'(target_y) * MPW'(step_q);

			act_s2 <= act_s1;
			idx_s2 <= idx_s1;
			rgb_s2 <= rgb_s1;
			px_s2 <= PW'(crop_x_q) + PW'(mx_s1);
			py_s2 <= PW'(crop_y_q) + PW'(my_s1);

			act_s3 <= act_s2;
			idx_s3 <= idx_s2;
			rgb_s3 <= rgb_s2;
			ix_s3 <= clx ? SDW'(iw_q - 1'b1) : ipx[SDW-1:0];
			ix1_s3 <= clx ? SDW'(iw_q - 1'b1) : SDW'(ipx[SDW-1:0] + 1'b1);
			fx_s3 <= clx ? 8'd0 : px_s2[15:8];
			iy_s3 <= cly ? SDW'(ih_q - 1'b1) : ipy[SDW-1:0];
			iy1_s3 <= cly ? SDW'(ih_q - 1'b1) : SDW'(ipy[SDW-1:0] + 1'b1);
			fy_s3 <= cly ? 8'd0 : py_s2[15:8];

			act_s4 <= act_s3;
			idx_s4 <= idx_s3;
			rgb_s4 <= rgb_s3;
			ix_s4 <= ix_s3;
			ix1_s4 <= ix1_s3;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			row0_s4 <= RW'(iy_s3) * RW'(iw_q);
			row1_s4 <= RW'(iy1_s3) * RW'(iw_q);

			act_s5 <= act_s4;
			idx_s5 <= idx_s4;
			rgb_s5 <= rgb_s4;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			a00_s5 <= a00;
			a01_s5 <= a01;
			a10_s5 <= a10;
			a11_s5 <= a11;

			fx_s6 <= fx_s5;
			fy_s6 <= fy_s5;

			fy_s7 <= fy_s6;
			top_s7 <= top_d;
			bot_s7 <= bot_d;

			pix_q <= {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
		end
	end

	// Stage five holds either a load, which writes both copies of the store, or a render,
	// which reads its four neighbors; both copies keep identical contents.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s5 && !act_s5) begin
				store_a_q[idx_s5] <= rgb_s5;
				store_b_q[idx_s5] <= rgb_s5;
			end
			rd00_s6 <= store_a_q[a00_s5];
			rd01_s6 <= store_a_q[a01_s5];
			rd10_s6 <= store_b_q[a10_s5];
			rd11_s6 <= store_b_q[a11_s5];
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_rgb565 = pix_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (state_q == SEQ_IDLE))
		else $error("item_ready high while the scale sequencer runs");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (state_q == SEQ_LIMIT))
		else $error("register write did not restart the scale sequencer");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_DIVIDE) |-> (cnt_q < CNW'(DVW)))
		else $error("divider step count overran");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s7) && $stable(pix_q))
		else $error("pipeline moved during an output stall");
`endif

endmodule
